@@ src/atle_pkg.sv @@
// shared types, widths and codes for the terminal line editor
// no dependencies; compiled first
package atle_pkg;

  localparam int unsigned RAW_W      = 8;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned BF_W       = 5;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  localparam int unsigned LINE_UNIT_DEF        = 100;
  localparam int unsigned MAX_BLOCK_FACTOR_DEF = 20;
  localparam int unsigned QUEUE_DEPTH          = 2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;
  localparam logic [CHAR_W-1:0] CH_BEL   = 7'h07;
  localparam logic [CHAR_W-1:0] CH_BS    = 7'h08;
  localparam logic [CHAR_W-1:0] CH_LF    = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 7'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CH_DEL   = 7'h7F;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BACKSPACE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_EOL_CHAR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CURSOR_EN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CURSOR_MODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BLOCK_FACTOR = 3'd4;

  // register reset values
  localparam logic [CHAR_W-1:0] RST_BACKSPACE    = 7'd8;
  localparam logic [CHAR_W-1:0] RST_EOL_CHAR     = 7'd13;
  localparam logic              RST_CURSOR_EN    = 1'b1;
  localparam logic [MODE_W-1:0] RST_CURSOR_MODE  = 2'd3;
  localparam logic [BF_W-1:0]   RST_BLOCK_FACTOR = 5'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ECHO    = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_RETRACT = 2'd2,
    KIND_END     = 2'd3
  } kind_e;

  // work handed from front to back end
  typedef enum logic [1:0] {
    OP_ERASE = 2'd0,
    OP_BELL  = 2'd1,
    OP_EOL   = 2'd2,
    OP_DATA  = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [CHAR_W-1:0]  ch;
    logic [LEN_W-1:0]   len;
    logic               cr;
    logic               lf;
    logic               flush;
  } cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] bs_char;
    logic [CHAR_W-1:0] eol_char;
    logic              cursor_en;
    logic [MODE_W-1:0] cursor_mode;
    logic [BF_W-1:0]   block_factor;
  } cfg_t;

endpackage

@@ src/atle_intf.sv @@
// channel interfaces: input bytes, result beats, register writes
// depends on atle_pkg
interface atle_in_if import atle_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_char;
  logic             skip_cursor_pos;

  modport source (output valid, raw_char, skip_cursor_pos, input ready);
  modport sink   (input valid, raw_char, skip_cursor_pos, output ready);
endinterface

interface atle_out_if import atle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] out_char;
  logic [LEN_W-1:0]  line_length;
  logic              last_of_run;

  modport source (output valid, kind, out_char, line_length, last_of_run, input ready);
  modport sink   (input valid, kind, out_char, line_length, last_of_run, output ready);
endinterface

interface atle_cfg_if import atle_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/atle_front.sv @@
// front end: accepts bytes, classifies them, keeps the line count
// depends on atle_pkg and atle_intf
module atle_front import atle_pkg::*; #(
  parameter int unsigned LINE_UNIT        = LINE_UNIT_DEF,
  parameter int unsigned MAX_BLOCK_FACTOR = MAX_BLOCK_FACTOR_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  atle_in_if.sink   in_i,
  input  cfg_t      cfg_i,
  input  logic      q_full_i,
  output logic      push_o,
  output cmd_t      cmd_o
);

  logic [LEN_W-1:0]  count_q, count_d;
  logic [CHAR_W-1:0] ch;
  logic              dropped;
  logic              accept;
  logic [BF_W-1:0]   bf;
  logic [LEN_W-1:0]  limit;
  logic [LEN_W-1:0]  count_inc;

  assign ch      = in_i.raw_char[CHAR_W-1:0];
  assign dropped = (ch == CH_NUL) || (ch == CH_LF) || (ch == CH_DEL);
  assign in_i.ready = !q_full_i;
  assign accept  = in_i.valid && in_i.ready;
  assign push_o  = accept && !dropped;

  // flush threshold, block factor clamped to its legal range
  always_comb begin
    bf = cfg_i.block_factor;
    if (bf == '0) begin
      bf = BF_W'(1);
    end else if (bf > BF_W'(MAX_BLOCK_FACTOR)) begin
      bf = BF_W'(MAX_BLOCK_FACTOR);
    end
  end

  assign limit     = LEN_W'(bf) * LEN_W'(LINE_UNIT);
  assign count_inc = count_q + LEN_W'(1);

  always_comb begin
    count_d     = count_q;
    cmd_o.op    = OP_DATA;
    cmd_o.ch    = ch;
    cmd_o.len   = '0;
    cmd_o.cr    = 1'b0;
    cmd_o.lf    = 1'b0;
    cmd_o.flush = 1'b0;
    if (ch == cfg_i.bs_char) begin
      if (count_q != '0) begin
        cmd_o.op = OP_ERASE;
        count_d  = count_q - LEN_W'(1);
      end else begin
        cmd_o.op = OP_BELL;
      end
    end else if (ch == cfg_i.eol_char) begin
      cmd_o.op  = OP_EOL;
      cmd_o.len = count_q;
      cmd_o.cr  = !in_i.skip_cursor_pos && cfg_i.cursor_en && cfg_i.cursor_mode[0];
      cmd_o.lf  = !in_i.skip_cursor_pos && cfg_i.cursor_en && cfg_i.cursor_mode[1];
      count_d   = '0;
    end else begin
      cmd_o.op    = OP_DATA;
      cmd_o.len   = count_inc;
      cmd_o.flush = (count_inc >= limit);
      count_d     = cmd_o.flush ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (push_o) begin
      count_q <= count_d;
    end
  end

endmodule

@@ src/atle_queue.sv @@
// short command queue between front and back end
// depends on atle_pkg
module atle_queue import atle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ src/atle_back.sv @@
// back end: expands one command into its result beats, one per cycle while the output is ready
// depends on atle_pkg and atle_intf
module atle_back import atle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  atle_out_if.source  out_o
);

  logic [1:0]        step_q, step_d;
  logic              load;
  logic              last;
  kind_e             kind;
  logic [CHAR_W-1:0] chr;
  logic [LEN_W-1:0]  len;

  logic              valid_q;
  kind_e             kind_q;
  logic [CHAR_W-1:0] chr_q;
  logic [LEN_W-1:0]  len_q;
  logic              last_q;

  // beat for the current step of the head command
  always_comb begin
    kind = KIND_ECHO;
    chr  = '0;
    len  = '0;
    last = 1'b1;
    case (cmd_i.op)
      OP_ERASE: begin
        last = (step_q == 2'd3);
        case (step_q)
          2'd0:    kind = KIND_RETRACT;
          2'd2:    chr  = CH_SPACE;
          default: chr  = CH_BS;
        endcase
      end
      OP_BELL: begin
        chr = CH_BEL;
      end
      OP_EOL: begin
        case (step_q)
          2'd0: begin
            chr  = cmd_i.ch;
            last = 1'b0;
          end
          2'd1: begin
            kind = KIND_END;
            len  = cmd_i.len;
            last = !(cmd_i.cr || cmd_i.lf);
          end
          2'd2: begin
            chr  = cmd_i.cr ? CH_CR : CH_LF;
            last = !(cmd_i.cr && cmd_i.lf);
          end
          default: chr = CH_LF;
        endcase
      end
      default: begin
        case (step_q)
          2'd0: begin
            chr  = cmd_i.ch;
            last = 1'b0;
          end
          2'd1: begin
            kind = KIND_DATA;
            chr  = cmd_i.ch;
            last = !cmd_i.flush;
          end
          default: begin
            kind = KIND_END;
            len  = cmd_i.len;
          end
        endcase
      end
    endcase
  end

  assign load   = q_valid_i && (!valid_q || out_o.ready);
  assign pop_o  = load && last;
  assign step_d = last ? 2'd0 : step_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        step_q <= step_d;
      end
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind;
      chr_q  <= chr;
      len_q  <= len;
      last_q <= last;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.kind        = KIND_W'(kind_q);
  assign out_o.out_char    = chr_q;
  assign out_o.line_length = len_q;
  assign out_o.last_of_run = last_q;

endmodule

@@ src/async_terminal_line_editor_core.sv @@
// top level of the canonical-mode terminal line editor
// depends on atle_pkg, atle_intf, atle_front, atle_queue, atle_back

// Takes one terminal byte per input beat, strips the parity bit and turns it
// into a run of one to four result beats (echo bytes, upline data, retracts
// and line ends); the final beat of a run carries last_of_run. NUL, LF and
// DEL give no result. A byte is accepted while the two-entry command queue
// has room; the back end then emits one result beat per cycle, while the
// output is ready, through its output register. A bell makes one echo-only
// result beat, data two or three, end of line two to four and an erase four.
// Dropped bytes take no back end time. Sustained rate is set by the back
// end's beat serializer. Registers are written over the cfg channel, which is
// always ready, and are to be changed only while no run is in flight.
module async_terminal_line_editor_core import atle_pkg::*; #(
  parameter int unsigned LINE_UNIT        = LINE_UNIT_DEF,
  parameter int unsigned MAX_BLOCK_FACTOR = MAX_BLOCK_FACTOR_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  atle_in_if.sink     in_i,
  atle_out_if.source  out_o,
  atle_cfg_if.sink    cfg_i
);

  cfg_t cfg_q;
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic q_full;
  logic q_valid;
  logic pop;

  // register file; writes to indexes past the list are ignored
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bs_char      <= RST_BACKSPACE;
      cfg_q.eol_char     <= RST_EOL_CHAR;
      cfg_q.cursor_en    <= RST_CURSOR_EN;
      cfg_q.cursor_mode  <= RST_CURSOR_MODE;
      cfg_q.block_factor <= RST_BLOCK_FACTOR;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_IDX_BACKSPACE:    cfg_q.bs_char      <= cfg_i.data[CHAR_W-1:0];
        CFG_IDX_EOL_CHAR:     cfg_q.eol_char     <= cfg_i.data[CHAR_W-1:0];
        CFG_IDX_CURSOR_EN:    cfg_q.cursor_en    <= cfg_i.data[0];
        CFG_IDX_CURSOR_MODE:  cfg_q.cursor_mode  <= cfg_i.data[MODE_W-1:0];
        CFG_IDX_BLOCK_FACTOR: cfg_q.block_factor <= cfg_i.data[BF_W-1:0];
        default: ;
      endcase
    end
  end

  // classify bytes and track the line length
  atle_front #(
    .LINE_UNIT        (LINE_UNIT),
    .MAX_BLOCK_FACTOR (MAX_BLOCK_FACTOR)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  // decouples byte intake from result output
  atle_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  // one result beat per cycle into the output register while the output is ready
  atle_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .cmd_i     (head_cmd),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule
